### hdl/cfw_pkg.sv
// Shared constants, codes and control types for the column field entab writer.
`default_nettype none

package cfw_pkg;

  localparam int unsigned COL_W      = 8;
  localparam int unsigned MAX_COL    = 255;
  localparam int unsigned TAB_STOP   = 8;
  localparam int unsigned PH_W       = $clog2(TAB_STOP);
  localparam int unsigned MOVE_LIMIT = 63;
  localparam int unsigned BUD_W      = $clog2(MOVE_LIMIT + 1);

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;

  localparam logic [CMD_W-1:0] CMD_CHAR     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEG_END  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LINE_END = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [COL_W-1:0] FW_RESET = 8'd80;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  // word index of the field width register
  localparam logic REG_FIELD_WIDTH = 1'b0;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } cfw_cmd_t;

  typedef struct packed {
    logic need_nl;
    logic need_move;
    logic at_final;
    logic emit_ok;
  } cfw_stat_t;

endpackage

`default_nettype wire

### hdl/cfw_if.sv
// Valid/ready stream interfaces for the input item and the emitted byte.
`default_nettype none

interface cfw_in_if;
  logic                                valid;
  logic                                ready;
  logic [cfw_pkg::CMD_W-1:0]           command;
  logic [cfw_pkg::CHAR_W-1:0]          char_code;
  logic [cfw_pkg::CHAR_W-1:0]          separator;

  modport source (output valid, command, char_code, separator, input ready);
  modport sink   (input valid, command, char_code, separator, output ready);
endinterface

interface cfw_out_if;
  logic                                valid;
  logic                                ready;
  logic [cfw_pkg::CHAR_W-1:0]          out_char;
  logic                                last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

`default_nettype wire

### hdl/cfw_ctrl.sv
// Sequencing state machine: accept, execute, then step out motion bytes.
`default_nettype none

module cfw_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  cfw_pkg::cfw_stat_t  stat_i,
  output cfw_pkg::cfw_cmd_t   cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.need_nl) begin
          if (stat_i.emit_ok) begin
            cmd_o.exec = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.need_move ? S_MOVE : S_IDLE;
        end
      end
      S_MOVE: begin
        if (stat_i.emit_ok) begin
          cmd_o.step = 1'b1;
          if (stat_i.at_final) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/cfw_dp.sv
// Column state, motion generation and the output word register.
`default_nettype none

module cfw_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  [cfw_pkg::COL_W-1:0]        field_width_i,
  input  wire  [cfw_pkg::CMD_W-1:0]        command_i,
  input  wire  [cfw_pkg::CHAR_W-1:0]       char_code_i,
  input  wire  [cfw_pkg::CHAR_W-1:0]       separator_i,
  input  cfw_pkg::cfw_cmd_t                cmd_i,
  output cfw_pkg::cfw_stat_t               stat_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [cfw_pkg::CHAR_W-1:0]       out_char_o,
  output logic                             out_last_o
);

  localparam int unsigned CW = cfw_pkg::COL_W;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > (CW+1)'(cfw_pkg::MAX_COL)) ? CW'(cfw_pkg::MAX_COL) : s[CW-1:0];
  endfunction

  logic [cfw_pkg::CMD_W-1:0]  cmd_q;
  logic [cfw_pkg::CHAR_W-1:0] ch_q, sep_q, put_q, put_d;
  logic [CW-1:0]              out_col_q, out_col_d, tgt_q, tgt_d;
  logic [CW-1:0]              seg_stop_q, seg_stop_d, pend_q, pend_d;
  logic                       in_seg_q, in_seg_d, pend_en_q, pend_en_d;
  logic [cfw_pkg::PH_W-1:0]   ph_q, ph_d;
  logic [cfw_pkg::BUD_W-1:0]  bud_q, bud_d;
  logic                       ov_q, ov_d, olast_q, olast_d;
  logic [cfw_pkg::CHAR_W-1:0] ochar_q, ochar_d;

  logic          emit_ok, ch_move, sep_move, bud_nz, tab_go, sp_go, bs_go, final_w;
  logic [CW:0]   next_tab;
  logic [CW-1:0] stop, col_inc;
  logic [cfw_pkg::PH_W-1:0] ph_inc, ph_dec;

  assign emit_ok  = !ov_q || out_ready_i;
  assign ch_move  = (ch_q != cfw_pkg::CH_SPACE) && (ch_q != cfw_pkg::CH_BS);
  assign sep_move = (sep_q != '0) && (sep_q != cfw_pkg::CH_SPACE) && (sep_q != cfw_pkg::CH_BS);

  assign next_tab = {1'b0, out_col_q} - (CW+1)'(ph_q) + (CW+1)'(cfw_pkg::TAB_STOP);
  assign bud_nz   = (bud_q != '0);
  assign tab_go   = bud_nz && (next_tab <= {1'b0, tgt_q});
  assign sp_go    = bud_nz && (out_col_q < tgt_q);
  assign bs_go    = bud_nz && (out_col_q > tgt_q);
  assign final_w  = !(tab_go || sp_go || bs_go);

  assign col_inc = sat_add(out_col_q, CW'(1));
  assign ph_inc  = (ph_q == cfw_pkg::PH_W'(cfw_pkg::TAB_STOP - 1)) ? '0 : ph_q + 1'b1;
  assign ph_dec  = (ph_q == '0) ? cfw_pkg::PH_W'(cfw_pkg::TAB_STOP - 1) : ph_q - 1'b1;

  always_comb begin
    stop = in_seg_q ? seg_stop_q : sat_add(tgt_q, field_width_i);
    if (sep_q != '0) begin
      stop = sat_add(tgt_q, CW'(1));
    end
  end

  assign stat_o.need_nl   = (cmd_q == cfw_pkg::CMD_LINE_END);
  assign stat_o.need_move = ((cmd_q == cfw_pkg::CMD_CHAR) && ch_move) ||
                            ((cmd_q == cfw_pkg::CMD_SEG_END) && sep_move);
  assign stat_o.at_final  = final_w;
  assign stat_o.emit_ok   = emit_ok;

  always_comb begin
    out_col_d  = out_col_q;
    ph_d       = ph_q;
    tgt_d      = tgt_q;
    seg_stop_d = seg_stop_q;
    in_seg_d   = in_seg_q;
    pend_d     = pend_q;
    pend_en_d  = pend_en_q;
    bud_d      = bud_q;
    put_d      = put_q;
    ov_d       = ov_q && !out_ready_i;
    ochar_d    = ochar_q;
    olast_d    = olast_q;

    if (cmd_i.exec) begin
      case (cmd_q)
        cfw_pkg::CMD_CHAR: begin
          if (!in_seg_q) begin
            seg_stop_d = sat_add(tgt_q, field_width_i);
            in_seg_d   = 1'b1;
          end
          if (ch_q == cfw_pkg::CH_SPACE) begin
            tgt_d = sat_add(tgt_q, CW'(1));
          end else if (ch_q == cfw_pkg::CH_BS) begin
            tgt_d = (tgt_q != '0) ? tgt_q - 1'b1 : tgt_q;
          end else begin
            bud_d     = cfw_pkg::BUD_W'(cfw_pkg::MOVE_LIMIT);
            put_d     = ch_q;
            pend_en_d = 1'b0;
          end
        end
        cfw_pkg::CMD_SEG_END: begin
          if (sep_move) begin
            bud_d     = cfw_pkg::BUD_W'(cfw_pkg::MOVE_LIMIT);
            put_d     = sep_q;
            pend_d    = stop;
            pend_en_d = 1'b1;
          end else begin
            tgt_d = stop;
          end
          in_seg_d   = 1'b0;
          seg_stop_d = '0;
        end
        cfw_pkg::CMD_LINE_END: begin
          ov_d       = 1'b1;
          ochar_d    = cfw_pkg::CH_NL;
          olast_d    = 1'b1;
          out_col_d  = '0;
          ph_d       = '0;
          tgt_d      = '0;
          in_seg_d   = 1'b0;
          seg_stop_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.step) begin
      ov_d    = 1'b1;
      olast_d = final_w;
      bud_d   = bud_nz ? bud_q - 1'b1 : bud_q;
      if (tab_go) begin
        ochar_d   = cfw_pkg::CH_TAB;
        out_col_d = next_tab[CW-1:0];
        ph_d      = '0;
      end else if (sp_go) begin
        ochar_d   = cfw_pkg::CH_SPACE;
        out_col_d = out_col_q + 1'b1;
        ph_d      = ph_inc;
      end else if (bs_go) begin
        ochar_d   = cfw_pkg::CH_BS;
        out_col_d = out_col_q - 1'b1;
        ph_d      = ph_dec;
      end else begin
        ochar_d   = put_q;
        out_col_d = col_inc;
        if (out_col_q != CW'(cfw_pkg::MAX_COL)) begin
          ph_d = ph_inc;
        end
        tgt_d     = pend_en_q ? pend_q : col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q  <= '0;
      ph_q       <= '0;
      tgt_q      <= '0;
      seg_stop_q <= '0;
      in_seg_q   <= 1'b0;
      pend_en_q  <= 1'b0;
      bud_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      out_col_q  <= out_col_d;
      ph_q       <= ph_d;
      tgt_q      <= tgt_d;
      seg_stop_q <= seg_stop_d;
      in_seg_q   <= in_seg_d;
      pend_en_q  <= pend_en_d;
      bud_q      <= bud_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      ch_q  <= char_code_i;
      sep_q <= separator_i;
    end
    pend_q  <= pend_d;
    put_q   <= put_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q <= cfw_pkg::PH_W'(cfw_pkg::TAB_STOP - 1))
    else $error("tab phase out of range");

  a_seg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_seg_q |-> (seg_stop_q == '0))
    else $error("segment stop held outside a segment");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step || (cmd_i.exec && stat_o.need_nl)) |-> emit_ok)
    else $error("word emitted over a pending word");

  a_budget_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && stat_o.need_move) |=> (bud_q == cfw_pkg::BUD_W'(cfw_pkg::MOVE_LIMIT)))
    else $error("motion budget not loaded");

  a_target_after_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && final_w && !pend_en_q) |=> (tgt_q == out_col_q))
    else $error("target column not aligned after byte");

endmodule

`default_nettype wire

### hdl/column_field_entab_writer.sv
// Top level: configuration port, control state machine and column datapath.
//
//  channel   dir  protocol      word
//  in_i      in   valid/ready   command, char_code, separator
//  out_o     out  valid/ready   out_char, last
//  apb       in   APB write/rd  field_width at address 0
//
//  An item is accepted, then executed; an item that emits a byte then steps
//  out its words (motion bytes plus the byte) through the single output word
//  register, and the next item is not accepted until its last word is loaded.
//  Reset is asynchronous and active low; columns clear, field width is 80.
//  A stalled output holds the word register and the sequencer waits on it.
`default_nettype none

module column_field_entab_writer (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  cfw_in_if.sink                             in_i,
  cfw_out_if.source                          out_o,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [cfw_pkg::APB_AW-1:0]         paddr,
  input  wire  [cfw_pkg::APB_DW-1:0]         pwdata,
  output logic [cfw_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  logic [cfw_pkg::COL_W-1:0] fw_q;
  logic                      fw_sel;
  cfw_pkg::cfw_cmd_t         cmd;
  cfw_pkg::cfw_stat_t        stat;

  assign pready = 1'b1;
  assign fw_sel = (paddr[2] == cfw_pkg::REG_FIELD_WIDTH);
  assign prdata = fw_sel ? {{(cfw_pkg::APB_DW - cfw_pkg::COL_W){1'b0}}, fw_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= cfw_pkg::FW_RESET;
    end else if (psel && penable && pwrite && fw_sel) begin
      fw_q <= pwdata[cfw_pkg::COL_W-1:0];
    end
  end

  cfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfw_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .field_width_i (fw_q),
    .command_i     (in_i.command),
    .char_code_i   (in_i.char_code),
    .separator_i   (in_i.separator),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_char_o    (out_o.out_char),
    .out_last_o    (out_o.last)
  );

endmodule

`default_nettype wire
